// ----- sv/decimal_text_to_fixed_point_assert.svh -----
// assertion macros used by the checker file of the decimal text converter
// no dependencies; clk and rst_n must be visible where a macro is used
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DTFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define DTFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dtfp_pkg.sv -----
// shared types and constants of the decimal text to fixed-point converter
// no dependencies
`timescale 1ns / 1ps

package dtfp_pkg;

  localparam int CHAR_W      = 8;
  localparam int SCALE_W     = 5;
  localparam int VALUE_W     = 63;
  // one pad stage multiplies by at most one hundred (seven bits)
  localparam int PROD_W      = VALUE_W + 7;
  localparam int MAX_SCALE   = 18;
  // each pad stage takes up to two decimal digits of padding
  localparam int PAD_STAGES  = (MAX_SCALE + 1) / 2;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

  // result item on its way through the padding pipeline
  typedef struct packed {
    logic               ok;
    logic [SCALE_W-1:0] rem;
    logic [VALUE_W-1:0] val;
  } pad_t;

endpackage

// ----- sv/dtfp_if.sv -----
// channel interfaces of the decimal text to fixed-point converter
// depends on dtfp_pkg
`timescale 1ns / 1ps

// character input channel
interface dtfp_in_if;
  import dtfp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;
  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
  modport mon    (input valid, ready, char_code, is_last);
endinterface

// result channel
interface dtfp_out_if;
  import dtfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] fixed_value;
  logic               valid_res;
  modport source (output valid, fixed_value, valid_res, input ready);
  modport sink   (input valid, fixed_value, valid_res, output ready);
  modport mon    (input valid, ready, fixed_value, valid_res);
endinterface

// frac_scale register write channel
interface dtfp_cfg_if;
  import dtfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] frac_scale;
  modport source (output valid, frac_scale, input ready);
  modport sink   (input valid, frac_scale, output ready);
  modport mon    (input valid, ready, frac_scale);
endinterface

// ----- sv/dtfp_parse.sv -----
// per-character parse state and end-of-text check
// depends on dtfp_pkg
`timescale 1ns / 1ps

module dtfp_parse import dtfp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] frac_scale,
  input  logic               take,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               is_last,
  output logic               fin_valid,
  output pad_t               fin_data
);

  logic [VALUE_W-1:0] accum_r, accum_nxt;
  logic [SCALE_W-1:0] frac_count_r, frac_count_nxt;
  logic               after_point_r, after_point_nxt;
  logic               digit_seen_r, digit_seen_nxt;
  logic               error_seen_r, error_seen_nxt;

  logic               is_dot;
  logic               is_digit;
  logic [3:0]         digit;
  logic [VALUE_W+3:0] wide;
  logic               ok;

  // character classes and accumulate candidate
  always_comb begin
    is_dot   = (char_code == CH_DOT);
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    digit    = 4'(char_code - CH_ZERO);
    wide     = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1)
             + {{VALUE_W{1'b0}}, digit};
  end

  // one character step
  always_comb begin
    accum_nxt       = accum_r;
    frac_count_nxt  = frac_count_r;
    after_point_nxt = after_point_r;
    digit_seen_nxt  = digit_seen_r;
    error_seen_nxt  = error_seen_r;
    if (!error_seen_r) begin
      if (is_dot) begin
        if (after_point_r || !digit_seen_r) begin
          error_seen_nxt = 1'b1;
        end else begin
          after_point_nxt = 1'b1;
        end
      end else if (!is_digit) begin
        error_seen_nxt = 1'b1;
      end else begin
        digit_seen_nxt = 1'b1;
        if (after_point_r && (frac_count_r >= frac_scale)) begin
          // digits past the scale must be zero and are dropped
          if (char_code != CH_ZERO) begin
            error_seen_nxt = 1'b1;
          end
        end else if (|wide[VALUE_W+3:VALUE_W]) begin
          error_seen_nxt = 1'b1;
        end else begin
          accum_nxt = wide[VALUE_W-1:0];
          if (after_point_r) begin
            frac_count_nxt = frac_count_r + 1'b1;
          end
        end
      end
    end
  end

  // end-of-text check and padding count
  always_comb begin
    ok = !error_seen_nxt && digit_seen_nxt && !is_dot &&
         (frac_scale <= SCALE_W'(MAX_SCALE));
    fin_valid    = take && is_last;
    fin_data.ok  = ok;
    fin_data.val = ok ? accum_nxt : '0;
    fin_data.rem = (ok && (frac_scale > frac_count_nxt)) ?
                   (frac_scale - frac_count_nxt) : '0;
  end

  // state update, cleared after the last character of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r       <= '0;
      frac_count_r  <= '0;
      after_point_r <= 1'b0;
      digit_seen_r  <= 1'b0;
      error_seen_r  <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        accum_r       <= '0;
        frac_count_r  <= '0;
        after_point_r <= 1'b0;
        digit_seen_r  <= 1'b0;
        error_seen_r  <= 1'b0;
      end else begin
        accum_r       <= accum_nxt;
        frac_count_r  <= frac_count_nxt;
        after_point_r <= after_point_nxt;
        digit_seen_r  <= digit_seen_nxt;
        error_seen_r  <= error_seen_nxt;
      end
    end
  end

endmodule

// ----- sv/dtfp_pad_stage.sv -----
// one stage of the padding pipeline: up to two decimal zeros and overflow check
// depends on dtfp_pkg
`timescale 1ns / 1ps

module dtfp_pad_stage import dtfp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  pad_t up_data,
  output logic up_ready,
  input  logic dn_ready,
  output logic valid_r,
  output pad_t data_r
);

  logic [PROD_W-1:0] ext;
  logic [PROD_W-1:0] prod;
  logic              over;
  pad_t              data_nxt;

  // multiply by one, ten or one hundred with shift-adds
  always_comb begin
    ext = {{(PROD_W-VALUE_W){1'b0}}, up_data.val};
    data_nxt.rem = up_data.rem;
    if (up_data.rem >= SCALE_W'(2)) begin
      prod         = (ext << 6) + (ext << 5) + (ext << 2);
      data_nxt.rem = up_data.rem - SCALE_W'(2);
    end else if (up_data.rem == SCALE_W'(1)) begin
      prod         = (ext << 3) + (ext << 1);
      data_nxt.rem = '0;
    end else begin
      prod = ext;
    end
    over         = |prod[PROD_W-1:VALUE_W];
    data_nxt.ok  = up_data.ok && !over;
    data_nxt.val = data_nxt.ok ? prod[VALUE_W-1:0] : '0;
  end

  assign up_ready = !valid_r || dn_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- sv/decimal_text_to_fixed_point.sv -----
// top level of the decimal text to fixed-point converter
// depends on dtfp_pkg, dtfp_if, dtfp_parse and dtfp_pad_stage
//
//   port     dir   carries
//   cfg_ch   in    frac_scale register write (always ready)
//   in_ch    in    char_code, is_last: one character per item
//   out_ch   out   fixed_value, valid_res: one item per text
//
// one character is taken every cycle while the output is not blocked
// a result passes through all nine pad stages in order after the last character
// the pad stage chain sets the latency: up to two decimal zeros of padding per stage
// a stall on out_ch fills the pad stages before in_ch.ready drops
// synchronous active-low reset clears the parse state, valid bits and frac_scale
`timescale 1ns / 1ps

module decimal_text_to_fixed_point import dtfp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  dtfp_cfg_if.sink cfg_ch,
  dtfp_in_if.sink  in_ch,
  dtfp_out_if.source out_ch
);

  logic [SCALE_W-1:0]    frac_scale_r;
  logic                  take;
  logic                  fin_valid;
  pad_t                  fin_data;
  logic [PAD_STAGES-1:0] st_valid;
  logic [PAD_STAGES-1:0] st_ready;
  pad_t                  st_data [PAD_STAGES];

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_scale_r <= '0;
    end else if (cfg_ch.valid) begin
      frac_scale_r <= cfg_ch.frac_scale;
    end
  end

  // character parse
  assign in_ch.ready = st_ready[0];
  assign take        = in_ch.valid && in_ch.ready;

  dtfp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .frac_scale (frac_scale_r),
    .take       (take),
    .char_code  (in_ch.char_code),
    .is_last    (in_ch.is_last),
    .fin_valid  (fin_valid),
    .fin_data   (fin_data)
  );

  // padding pipeline, last stage is the output register
  for (genvar g = 0; g < PAD_STAGES; g++) begin : g_pad
    logic up_valid;
    pad_t up_data;
    logic dn_ready;

    if (g == 0) begin : g_first
      assign up_valid = fin_valid;
      assign up_data  = fin_data;
    end else begin : g_next
      assign up_valid = st_valid[g-1];
      assign up_data  = st_data[g-1];
    end

    if (g == PAD_STAGES - 1) begin : g_tail
      assign dn_ready = out_ch.ready;
    end else begin : g_body
      assign dn_ready = st_ready[g+1];
    end

    dtfp_pad_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (up_valid),
      .up_data  (up_data),
      .up_ready (st_ready[g]),
      .dn_ready (dn_ready),
      .valid_r  (st_valid[g]),
      .data_r   (st_data[g])
    );
  end

  // result channel
  assign out_ch.valid       = st_valid[PAD_STAGES-1];
  assign out_ch.fixed_value = st_data[PAD_STAGES-1].val;
  assign out_ch.valid_res   = st_data[PAD_STAGES-1].ok;

endmodule

// ----- sv/dtfp_checker.sv -----
// port-level checks of the decimal text to fixed-point converter, and its bind
// depends on dtfp_pkg, the top level's channel ports and decimal_text_to_fixed_point_assert.svh
`timescale 1ns / 1ps
`include "decimal_text_to_fixed_point_assert.svh"

module dtfp_checker import dtfp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [VALUE_W-1:0] out_fixed_value,
  input logic               out_valid_res
);

  logic             out_stall;
  logic             out_reject;
  logic [VALUE_W:0] out_payload;

  // result side views
  assign out_stall   = out_valid && !out_ready;
  assign out_reject  = out_valid && !out_valid_res;
  assign out_payload = {out_fixed_value, out_valid_res};

  // a stalled result item holds its payload
  `DTFP_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "result item changed")

  // a rejected text gives a zero value
  `DTFP_ASSERT_NOW(a_reject_zero, out_reject, out_fixed_value == '0, "rejected text nonzero")

  // input backpressure only comes from a blocked output
  `DTFP_ASSERT_NOW(a_in_stall, !in_ready, out_stall, "input stalled with output free")

  // the register port never stalls
  `DTFP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write stalled")

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .cfg_valid       (cfg_ch.valid),
  .cfg_ready       (cfg_ch.ready),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_fixed_value (out_ch.fixed_value),
  .out_valid_res   (out_ch.valid_res)
);

// ----- sim/tb_top.sv -----
// testbench of the decimal text to fixed-point converter: directed table, then random texts
// depends on dtfp_pkg, dtfp_if and decimal_text_to_fixed_point
`timescale 1ns / 1ps

module tb_top;
  import dtfp_pkg::*;

  localparam int          PIPE_DRAIN  = 12;    // nine pad stages plus margin
  localparam int          QUIET_LIMIT = 5000;  // cycles with no handshake at all
  localparam int          RAND_CHARS  = 2000;
  localparam int          HOLD_CYCLES = 600;
  localparam int          N_DIR       = 22;
  localparam logic [7:0]  CH_PLUS     = 8'h2B;
  localparam logic [7:0]  CH_MINUS    = 8'h2D;
  localparam longint unsigned VALUE_MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_TOP = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] fixed_value;
    logic               valid_res;
  } fxp_result_t;

  typedef enum logic {CHK_TYPED, CHK_MODEL} row_chk_t;

  typedef struct {
    int unsigned        scale;
    string              text;
    row_chk_t           chk;
    logic [VALUE_W-1:0] value;
    logic               ok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dtfp_cfg_if cfg_ch ();
  dtfp_in_if  in_ch ();
  dtfp_out_if out_ch ();

  decimal_text_to_fixed_point dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // converter state as the block should hold it
  int unsigned     scale_reg   = 0;
  longint unsigned dec_accum   = 0;
  int unsigned     dec_frac    = 0;
  bit              dec_after   = 1'b0;
  bit              dec_digit   = 1'b0;
  bit              dec_reject  = 1'b0;

  fxp_result_t exp_q [$];
  logic [7:0]  txt [$];
  int          err_count   = 0;
  int          quiet_cycles = 0;
  int          chars_sent  = 0;
  bit          gaps_on     = 1'b1;
  int          hold_len    = 0;

  // directed texts, grouped by scale; the first group runs on the reset scale
  dir_row_t dir_rows [N_DIR] = '{
    '{0,  "0",                    CHK_TYPED, 63'd0,     1'b1},
    '{0,  "9223372036854775807",  CHK_TYPED, VALUE_TOP, 1'b1},
    '{0,  "9223372036854775808",  CHK_TYPED, 63'd0,     1'b0},
    '{0,  "-1",                   CHK_TYPED, 63'd0,     1'b0},
    '{0,  "+5",                   CHK_TYPED, 63'd0,     1'b0},
    '{0,  ".5",                   CHK_TYPED, 63'd0,     1'b0},
    '{0,  "1.",                   CHK_TYPED, 63'd0,     1'b0},
    '{0,  "1.2.3",                CHK_TYPED, 63'd0,     1'b0},
    '{0,  "1.0",                  CHK_TYPED, 63'd1,     1'b1},
    '{0,  "1.5",                  CHK_TYPED, 63'd0,     1'b0},
    '{0,  "/:",                   CHK_TYPED, 63'd0,     1'b0},
    '{0,  "7\377",                CHK_TYPED, 63'd0,     1'b0},
    '{0,  "0123456789",           CHK_MODEL, 63'd0,     1'b0},
    '{18, "9.223372036854775807", CHK_TYPED, VALUE_TOP, 1'b1},
    '{18, "10",                   CHK_TYPED, 63'd0,     1'b0},
    '{18, "1.5",                  CHK_MODEL, 63'd0,     1'b0},
    '{5,  "123.45",               CHK_MODEL, 63'd0,     1'b0},
    '{5,  "0.000000",             CHK_MODEL, 63'd0,     1'b0},
    '{5,  "12.3456789",           CHK_MODEL, 63'd0,     1'b0},
    '{5,  "12.3456700",           CHK_MODEL, 63'd0,     1'b0},
    '{31, "1",                    CHK_TYPED, 63'd0,     1'b0},
    '{19, "0",                    CHK_TYPED, 63'd0,     1'b0}
  };

  // append one character to the text being built
  function automatic void txt_add(input logic [7:0] c);
    txt.insert(txt.size(), c);
  endfunction

  // append one expected result item
  function automatic void exp_add(input fxp_result_t r);
    exp_q.insert(exp_q.size(), r);
  endfunction

  function automatic longint unsigned pow_ten(int unsigned n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  // one character through the parser; a result comes on the last one
  function automatic void convert_char(input logic [7:0] c, input logic last,
                                       output bit produced, output fxp_result_t res);
    longint unsigned d;
    longint unsigned p;
    int unsigned     need;
    bit              ok;
    res      = '0;
    produced = 1'b0;
    if (!dec_reject) begin
      if (c == CH_DOT) begin
        if (dec_after || !dec_digit) dec_reject = 1'b1;
        else dec_after = 1'b1;
      end else if (c < CH_ZERO || c > CH_NINE) begin
        dec_reject = 1'b1;
      end else begin
        dec_digit = 1'b1;
        if (dec_after && dec_frac >= scale_reg) begin
          // digits past the scale: only zeros are allowed
          if (c != CH_ZERO) dec_reject = 1'b1;
        end else begin
          d = longint'(c - CH_ZERO);
          if (dec_accum > (VALUE_MAX64 - d) / 10) begin
            dec_reject = 1'b1;
          end else begin
            dec_accum = dec_accum * 10 + d;
            if (dec_after) dec_frac = (dec_frac + 1) & 5'h1F;
          end
        end
      end
    end
    if (last) begin
      produced = 1'b1;
      ok = !dec_reject && dec_digit && c != CH_DOT && scale_reg <= MAX_SCALE;
      if (ok) begin
        // pad up to the scale, checking for overflow
        need = scale_reg > dec_frac ? scale_reg - dec_frac : 0;
        if (need > MAX_SCALE) need = MAX_SCALE;
        p = pow_ten(need);
        if (dec_accum > VALUE_MAX64 / p) ok = 1'b0;
        else res.fixed_value = VALUE_W'(dec_accum * p);
      end
      res.valid_res = ok;
      dec_accum  = 0;
      dec_frac   = 0;
      dec_after  = 1'b0;
      dec_digit  = 1'b0;
      dec_reject = 1'b0;
    end
  endfunction

  // drive one character; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic last,
                           input bit use_typed, input fxp_result_t typed);
    int          gap;
    bit          produced;
    fxp_result_t pred;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.is_last   = last;
    do @(posedge clk); while (!in_ch.ready);
    convert_char(c, last, produced, pred);
    if (produced) exp_add(use_typed ? typed : pred);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input bit use_typed, input fxp_result_t typed);
    for (int i = 0; i < txt.size(); i++)
      send_char(txt[i], i == txt.size() - 1, use_typed, typed);
  endtask

  // scale write once the pipeline has drained
  task automatic write_scale(input int unsigned v);
    in_ch.valid = 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.frac_scale = SCALE_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    scale_reg = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // random text: mostly well-formed, some corrupted, some noise, some near the top
  task automatic make_text();
    int    kind;
    int    n_int;
    int    n_frac;
    int    pos;
    bit    zero_tail;
    string top_digits;
    top_digits = "92233720368547758";
    txt.delete();
    kind = $urandom_range(0, 9);
    if (kind == 7) begin
      repeat ($urandom_range(1, 6)) txt_add(8'($urandom_range(0, 255)));
    end else if (kind == 9) begin
      for (int i = 0; i < top_digits.len(); i++) txt_add(top_digits[i]);
      repeat (2) txt_add(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
      repeat (n_int) txt_add(8'(CH_ZERO + $urandom_range(0, 9)));
      if ($urandom_range(0, 1)) begin
        txt_add(CH_DOT);
        n_frac    = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 22) : $urandom_range(1, 6);
        zero_tail = $urandom_range(0, 1);
        for (int i = 0; i < n_frac; i++)
          txt_add((zero_tail && i >= scale_reg) ? CH_ZERO
                                               : 8'(CH_ZERO + $urandom_range(0, 9)));
      end
      if (kind == 8) begin
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 3))
          0: txt[pos] = CH_DOT;
          1: txt[pos] = CH_PLUS;
          2: txt[pos] = CH_MINUS;
          default: txt[pos] = 8'($urandom_range(0, 255));
        endcase
      end
    end
  endtask

  // main sequence
  initial begin
    fxp_result_t typed;
    int          phase;
    int          texts_left;
    int unsigned fixed_scales [4];
    fixed_scales = '{0, 18, 31, 1};
    in_ch.valid       = 1'b0;
    in_ch.char_code   = '0;
    in_ch.is_last     = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.frac_scale = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].scale != scale_reg) write_scale(dir_rows[r].scale);
      txt.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) txt_add(dir_rows[r].text[i]);
      typed.fixed_value = dir_rows[r].value;
      typed.valid_res   = dir_rows[r].ok;
      send_text(dir_rows[r].chk == CHK_TYPED, typed);
    end

    // random phases, each on its own scale
    chars_sent = 0;
    phase      = 0;
    typed      = '0;
    while (chars_sent < RAND_CHARS) begin
      if (phase < 4) write_scale(fixed_scales[phase]);
      else if ($urandom_range(0, 3) == 0) write_scale($urandom_range(19, 31));
      else write_scale($urandom_range(0, 18));
      gaps_on = (phase % 4) != 3;
      if (phase == 2) hold_len = HOLD_CYCLES;
      texts_left = $urandom_range(10, 40);
      while (texts_left > 0 && chars_sent < RAND_CHARS) begin
        make_text();
        send_text(1'b0, typed);
        texts_left--;
      end
      phase++;
    end

    // drain and finish
    in_ch.valid = 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DRAIN) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls per item while gaps_on is set, one long hold on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      out_ch.ready = 1'b0;
      repeat (stall) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    fxp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: value %0d valid %0b",
                   out_ch.fixed_value, out_ch.valid_res);
      end else begin
        want = exp_q.pop_front();
        if (out_ch.fixed_value !== want.fixed_value || out_ch.valid_res !== want.valid_res) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: expected value %0d valid %0b, got value %0d valid %0b",
                     want.fixed_value, want.valid_res,
                     out_ch.fixed_value, out_ch.valid_res);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

// ----- decimal_text_to_fixed_point.f -----
+incdir+sv
sv/dtfp_pkg.sv
sv/dtfp_if.sv
sv/dtfp_parse.sv
sv/dtfp_pad_stage.sv
sv/decimal_text_to_fixed_point.sv
sv/dtfp_checker.sv
sim/tb_top.sv
